>>> rtl/core/lfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfi_pkg;

	// Field formats
	localparam int SAMPLE_WIDTH   = 16;
	localparam int COEF_FRAC_BITS = 17;
	localparam int OUT_WIDTH      = 26;
	localparam int COEF_WIDTH     = COEF_FRAC_BITS + 1;
	localparam int ACC_WIDTH      = OUT_WIDTH + COEF_FRAC_BITS;
	localparam int HIST_DEPTH     = 6;

	// Stream byte widths
	localparam int IN_TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_WIDTH = ((OUT_WIDTH + 7) / 8) * 8;

	// FIR tap arithmetic: pre-add of a symmetric pair, product, sum of four products
	localparam int PAIR_WIDTH     = SAMPLE_WIDTH + 1;
	localparam int TAP_PROD_WIDTH = PAIR_WIDTH + COEF_WIDTH;
	localparam int TAP_SUM_WIDTH  = TAP_PROD_WIDTH + 2;

	// Leak arithmetic: accumulator split into whole part and fraction part
	localparam int HI_WIDTH       = ACC_WIDTH - COEF_FRAC_BITS;
	localparam int HI_PROD_WIDTH  = HI_WIDTH + COEF_WIDTH;
	localparam int LO_PROD_WIDTH  = COEF_FRAC_BITS + 1 + COEF_WIDTH;
	localparam int LO_TERM_WIDTH  = LO_PROD_WIDTH - COEF_FRAC_BITS;
	localparam int SUM_WIDTH      =
		((HI_PROD_WIDTH > TAP_SUM_WIDTH) ? HI_PROD_WIDTH : TAP_SUM_WIDTH) + 2;

	// Register map
	localparam int REG_IDX_WIDTH = 3;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_COEF_CENTER = 3'd0,
		REG_COEF_INNER  = 3'd1,
		REG_COEF_MIDDLE = 3'd2,
		REG_COEF_OUTER  = 3'd3,
		REG_LEAK        = 3'd4
	} reg_idx_t;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;

	typedef struct packed {
		coef_t center;
		coef_t inner;
		coef_t middle;
		coef_t outer;
		coef_t leak;
	} coef_set_t;

	// Reset weights of the windowed-sinc kernel and the leak
	localparam coef_t COEF_CENTER_RST = COEF_WIDTH'(111645);
	localparam coef_t COEF_INNER_RST  = COEF_WIDTH'(11628);
	localparam coef_t COEF_MIDDLE_RST = COEF_WIDTH'(-2196);
	localparam coef_t COEF_OUTER_RST  = COEF_WIDTH'(282);
	localparam coef_t LEAK_RST        = COEF_WIDTH'(130941);

endpackage

`default_nettype wire

>>> rtl/core/lfi_taps.sv
`timescale 1ns / 1ps
`default_nettype none

module lfi_taps import lfi_pkg::*; (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            load,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  sample,
	input  wire coef_set_t                       coefs,
	output logic signed [TAP_SUM_WIDTH-1:0]      tap_sum_s1
);

	logic signed [SAMPLE_WIDTH-1:0]   hist_q [HIST_DEPTH];
	logic signed [PAIR_WIDTH-1:0]     pair_outer;
	logic signed [PAIR_WIDTH-1:0]     pair_middle;
	logic signed [PAIR_WIDTH-1:0]     pair_inner;
	logic signed [PAIR_WIDTH-1:0]     center_ext;
	logic signed [TAP_PROD_WIDTH-1:0] prod_outer;
	logic signed [TAP_PROD_WIDTH-1:0] prod_middle;
	logic signed [TAP_PROD_WIDTH-1:0] prod_inner;
	logic signed [TAP_PROD_WIDTH-1:0] prod_center;
	logic signed [TAP_SUM_WIDTH-1:0]  tap_sum;

	// Pre-add the symmetric pairs around the centre tap
	assign pair_outer  = PAIR_WIDTH'(sample)    + PAIR_WIDTH'(hist_q[5]);
	assign pair_middle = PAIR_WIDTH'(hist_q[0]) + PAIR_WIDTH'(hist_q[4]);
	assign pair_inner  = PAIR_WIDTH'(hist_q[1]) + PAIR_WIDTH'(hist_q[3]);
	assign center_ext  = PAIR_WIDTH'(hist_q[2]);

	// Weight each pair
	assign prod_outer  = pair_outer  * coefs.outer;
	assign prod_middle = pair_middle * coefs.middle;
	assign prod_inner  = pair_inner  * coefs.inner;
	assign prod_center = center_ext  * coefs.center;

	assign tap_sum = TAP_SUM_WIDTH'(prod_outer) + TAP_SUM_WIDTH'(prod_middle)
		+ TAP_SUM_WIDTH'(prod_inner) + TAP_SUM_WIDTH'(prod_center);

	// Advance the delay line on every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (load) begin
			hist_q[0] <= sample;
			for (int i = 1; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// Capture the tap sum for the accumulate stage
	always_ff @(posedge clk) begin
		if (load) begin
			tap_sum_s1 <= tap_sum;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/leaky_fir_integrator.sv
`timescale 1ns / 1ps
`default_nettype none

// Leaky integrator over a 7-tap symmetric FIR.
// Input stream s_axis: one signed sample per transaction in tdata.
// Output stream m_axis: one integrated value per input transaction in tdata,
// with tuser high when the accumulator saturated on that step.
// Configuration: cfg_we with cfg_index 0..4 writes centre, inner, middle and
// outer weights and the leak factor, all signed Q0.17; other indexes are
// ignored. Write only while the block is idle.
// An accepted sample passes through the first stage and then the output
// register to m_axis. The sum of the FIR products is registered in the
// first stage; the leak multiply, the sum and the saturation form the
// second stage, a feedback loop on the accumulator register.
// Throughput: one transaction per cycle while m_axis_tready stays high.
// When the receiver stalls, the output holds and a sample is taken into the
// first stage only if it is empty; then s_axis_tready stays low until drained.
// Reset clears the delay line, the accumulator and the valid flags of both
// stages, and loads the default windowed-sinc weights and a leak of 0.999.
module leaky_fir_integrator import lfi_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [IN_TDATA_WIDTH-1:0]   s_axis_tdata,   // [15:0] sample
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [OUT_TDATA_WIDTH-1:0]       m_axis_tdata,   // [25:0] integrated
	output logic                             m_axis_tuser,   // [0] clipped
	input  wire logic                        cfg_we,
	input  wire logic [REG_IDX_WIDTH-1:0]    cfg_index,
	input  wire logic [COEF_WIDTH-1:0]       cfg_wdata
);

	localparam logic signed [LO_PROD_WIDTH-1:0] LO_HALF =
		LO_PROD_WIDTH'(1) << (COEF_FRAC_BITS - 1);

	coef_set_t                         coefs_q;
	logic                              valid_s1;
	logic                              out_valid_q;
	logic signed [OUT_WIDTH-1:0]       out_integrated_q;
	logic                              out_clipped_q;
	logic signed [ACC_WIDTH-1:0]       acc_q;

	logic                              s_accept;
	logic                              out_free;
	logic                              retire;
	logic signed [TAP_SUM_WIDTH-1:0]   tap_sum_s1;
	logic signed [HI_WIDTH-1:0]        acc_hi;
	logic signed [COEF_FRAC_BITS:0]    acc_lo;
	logic signed [HI_PROD_WIDTH-1:0]   hi_prod;
	logic signed [LO_PROD_WIDTH-1:0]   lo_prod;
	logic signed [LO_PROD_WIDTH-1:0]   lo_rnd;
	logic signed [LO_TERM_WIDTH-1:0]   lo_term;
	logic signed [SUM_WIDTH-1:0]       sum;
	logic [SUM_WIDTH-ACC_WIDTH:0]      sum_top;
	logic                              overflow;
	logic signed [ACC_WIDTH-1:0]       acc_next;

	// Handshake: the output register frees when empty or taken
	assign out_free      = !out_valid_q || m_axis_tready;
	assign retire        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.center <= COEF_CENTER_RST;
			coefs_q.inner  <= COEF_INNER_RST;
			coefs_q.middle <= COEF_MIDDLE_RST;
			coefs_q.outer  <= COEF_OUTER_RST;
			coefs_q.leak   <= LEAK_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COEF_CENTER: coefs_q.center <= cfg_wdata;
				REG_COEF_INNER:  coefs_q.inner  <= cfg_wdata;
				REG_COEF_MIDDLE: coefs_q.middle <= cfg_wdata;
				REG_COEF_OUTER:  coefs_q.outer  <= cfg_wdata;
				REG_LEAK:        coefs_q.leak   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// First stage: delay line and FIR products
	lfi_taps u_taps (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s_accept),
		.sample     (signed'(s_axis_tdata[SAMPLE_WIDTH-1:0])),
		.coefs      (coefs_q),
		.tap_sum_s1 (tap_sum_s1)
	);

	// Leak term: whole part exact, fraction part rounded half up
	assign acc_hi  = acc_q[ACC_WIDTH-1:COEF_FRAC_BITS];
	assign acc_lo  = signed'({1'b0, acc_q[COEF_FRAC_BITS-1:0]});
	assign hi_prod = acc_hi * coefs_q.leak;
	assign lo_prod = acc_lo * coefs_q.leak;
	assign lo_rnd  = lo_prod + LO_HALF;
	assign lo_term = lo_rnd[LO_PROD_WIDTH-1:COEF_FRAC_BITS];

	assign sum = SUM_WIDTH'(tap_sum_s1) + SUM_WIDTH'(hi_prod) + SUM_WIDTH'(lo_term);

	// Saturate to the accumulator range
	assign sum_top  = sum[SUM_WIDTH-1:ACC_WIDTH-1];
	assign overflow = !((&sum_top) || !(|sum_top));

	always_comb begin
		if (overflow) begin
			acc_next = sum[SUM_WIDTH-1] ? signed'({1'b1, {(ACC_WIDTH-1){1'b0}}})
			                            : signed'({1'b0, {(ACC_WIDTH-1){1'b1}}});
		end else begin
			acc_next = sum[ACC_WIDTH-1:0];
		end
	end

	// Stage valid, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				out_valid_q <= 1'b1;
				acc_q       <= acc_next;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			out_integrated_q <= acc_next[ACC_WIDTH-1:COEF_FRAC_BITS];
			out_clipped_q    <= overflow;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_WIDTH'(unsigned'(out_integrated_q));
	assign m_axis_tuser  = out_clipped_q;

`ifndef NO_ASSERTIONS
	a_acc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!retire |=> $stable(acc_q))
		else $error("accumulator changed without a retiring item");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_clipped_q) |->
			(out_integrated_q == signed'({1'b0, {(OUT_WIDTH-1){1'b1}}}) ||
			 out_integrated_q == signed'({1'b1, {(OUT_WIDTH-1){1'b0}}})))
		else $error("clipped result not at a range limit");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with an empty first stage");

	a_retire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> out_valid_q)
		else $error("retired item did not reach the output");
`endif

endmodule

`default_nettype wire
